/* design/u2u_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u2u_pkg;

    // Register map and APB geometry.
    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_WIDE_UNIT_MODE = 2'd0;

    // Default depth of the queue between front and back.
    localparam int unsigned FIFO_DEPTH_DEFAULT = 4;

    // Result kinds.
    localparam logic [1:0] KIND_UNIT = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Code point limits.
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
    localparam logic [20:0] CP_SUPP     = 21'h010000;
    localparam logic [20:0] CP_MIN_2B   = 21'h000080;
    localparam logic [20:0] CP_MIN_3B   = 21'h000800;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // Sequence lengths minus one.
    localparam logic [1:0] LEN_1B = 2'd0;
    localparam logic [1:0] LEN_2B = 2'd1;
    localparam logic [1:0] LEN_3B = 2'd2;
    localparam logic [1:0] LEN_4B = 2'd3;

    // One input transfer.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_string;
    } in_item_t;

    // One result transfer.
    typedef struct packed {
        logic [20:0] code_unit;
        logic [1:0]  result_kind;
        logic        last_of_run;
    } out_item_t;

    // Work handed from the front to the back for one input byte.
    typedef struct packed {
        logic [20:0] unit0;        // code point or high surrogate
        logic [15:0] unit1;        // low surrogate
        logic [1:0]  n_units;      // 0, 1 or 2 code units
        logic        has_status;   // string ends with this byte
        logic        status_ok;
    } job_t;

endpackage

/* design/u2u_front.sv */
// Front end: takes UTF-8 bytes, tracks the sequence state and builds output jobs.
module u2u_front
    import u2u_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wide_mode,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  logic     fifo_full,
    output logic     push,
    output job_t     push_job
);

    logic [20:0] partial_reg, partial_next;
    logic [1:0]  due_reg, due_next;
    logic [1:0]  len_reg, len_next;
    logic        err_reg, err_next;

    logic        accept;
    logic        complete;
    logic        bad;
    logic [7:0]  b;
    logic [20:0] cp;
    logic [20:0] v;
    job_t        job;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_data.byte_value;

    // Sequence tracking and result generation for the current byte.
    always_comb
    begin
        partial_next = partial_reg;
        due_next     = due_reg;
        len_next     = len_reg;
        err_next     = err_reg;
        complete     = 1'b0;
        job          = '0;

        if (!err_reg)
        begin
            if (due_reg == 2'd0)
            begin
                if (b[7] == 1'b0)
                begin
                    partial_next = {13'd0, b};
                    len_next     = LEN_1B;
                    complete     = 1'b1;
                end
                else if (b[7:5] == 3'b110)
                begin
                    partial_next = {16'd0, b[4:0]};
                    len_next     = LEN_2B;
                    due_next     = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    partial_next = {17'd0, b[3:0]};
                    len_next     = LEN_3B;
                    due_next     = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    partial_next = {18'd0, b[2:0]};
                    len_next     = LEN_4B;
                    due_next     = 2'd3;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                err_next = 1'b1;
            end
            else
            begin
                partial_next = {partial_reg[14:0], b[5:0]};
                due_next     = due_reg - 2'd1;
                complete     = (due_reg == 2'd1);
            end
        end

        // Validation of the completed code point.
        cp  = partial_next;
        v   = cp - CP_SUPP;
        bad = ((len_next == LEN_2B) && (cp < CP_MIN_2B)) ||
              ((len_next == LEN_3B) && (cp < CP_MIN_3B)) ||
              ((len_next == LEN_4B) && (cp < CP_SUPP)) ||
              (cp > CP_MAX) ||
              (cp inside {[CP_SURR_LO:CP_SURR_HI]});

        if (complete)
        begin
            if (bad)
            begin
                err_next = 1'b1;
            end
            else if (wide_mode || (cp < CP_SUPP))
            begin
                job.unit0   = cp;
                job.n_units = 2'd1;
            end
            else
            begin
                job.unit0   = {5'd0, HI_SURR_BASE + {6'd0, v[19:10]}};
                job.unit1   = LO_SURR_BASE + {6'd0, v[9:0]};
                job.n_units = 2'd2;
            end
            partial_next = '0;
            len_next     = LEN_1B;
        end

        // End of string: status result and state clear.
        if (in_data.end_of_string)
        begin
            job.has_status = 1'b1;
            job.status_ok  = !err_next && (due_next == 2'd0);
            partial_next   = '0;
            due_next       = 2'd0;
            len_next       = LEN_1B;
            err_next       = 1'b0;
        end
    end

    assign push     = accept && ((job.n_units != 2'd0) || job.has_status);
    assign push_job = job;

    // String state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            due_reg     <= '0;
            len_reg     <= '0;
            err_reg     <= 1'b0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            due_reg     <= due_next;
            len_reg     <= len_next;
            err_reg     <= err_next;
        end
    end

endmodule

/* design/u2u_fifo.sv */
// Small job queue between the front end and the output sequencer.
module u2u_fifo
    import u2u_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entries_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* design/u2u_back.sv */
// Back end: walks each job and sends its results one transfer per cycle while out_ready allows.
module u2u_back
    import u2u_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  job_t      head_job,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg;

    logic [1:0] total;
    logic       last;
    logic       load;
    out_item_t  item;

    // Pick the result at the current position within the job.
    always_comb
    begin
        total = head_job.n_units + {1'b0, head_job.has_status};
        last  = (idx_reg == total - 2'd1);
        item  = '0;
        if (idx_reg < head_job.n_units)
        begin
            item.code_unit   = (idx_reg == 2'd0) ? head_job.unit0 : {5'd0, head_job.unit1};
            item.result_kind = KIND_UNIT;
        end
        else
        begin
            item.code_unit   = '0;
            item.result_kind = head_job.status_ok ? KIND_OK : KIND_ERR;
        end
        item.last_of_run = last;
    end

    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && last;

    // Position counter and output valid.
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* design/utf8_to_utf16_transcoder.sv */
// UTF-8 to UTF-16 transcoder top level: APB register, front end, job queue, back end.
// Path: a result is stored in the job queue after its byte is accepted, then registered in
// the back end's output register, and transfers from there when the path is free.
// Throughput: one byte per cycle in; the back end sends one result per cycle while out_ready
// allows; a byte's further results (low surrogate, end-of-string status) each need a transfer.
// Input stalls only when the job queue (FIFO_DEPTH entries) is full.
// Reset (rst_n low, asynchronous) clears the string state, the queue and wide_unit_mode.
module utf8_to_utf16_transcoder
    import u2u_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic wide_reg;
    logic fifo_full;
    logic push;
    logic pop;
    logic head_valid;
    job_t push_job;
    job_t head_job;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WIDE_UNIT_MODE) ? {{(APB_DATA_W-1){1'b0}}, wide_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_WIDE_UNIT_MODE))
        begin
            wide_reg <= pwdata[0];
        end
    end

    u2u_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wide_mode (wide_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .fifo_full (fifo_full),
        .push      (push),
        .push_job  (push_job)
    );

    u2u_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (fifo_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u2u_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
